// File: rtl/tcld_pkg.sv
// tcld_pkg: shared types, constants and character tables for the text
// command line decoder. No dependencies.
`default_nettype none

package tcld_pkg;

    localparam int LINE_CHARS_DEF = 31;

    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    // Command lengths
    localparam int CMD_ON_LEN     = 6;
    localparam int CMD_OFF_LEN    = 7;
    localparam int CMD_STATUS_LEN = 6;

    // Reply lengths, CR LF included
    localparam int REPLY_ON_LEN  = 21;
    localparam int REPLY_OFF_LEN = 22;

    typedef enum logic [1:0] {
        REPLY_NONE,
        REPLY_ON,
        REPLY_OFF
    } reply_kind_t;

    // One decoded input transaction, handed to the emitter
    typedef struct packed {
        logic [7:0]  echo;
        logic        led;
        reply_kind_t kind;
    } tcld_job_t;

    // "led on"
    function automatic logic [7:0] cmd_on_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = "l";
            3'd1:    ch = "e";
            3'd2:    ch = "d";
            3'd3:    ch = " ";
            3'd4:    ch = "o";
            3'd5:    ch = "n";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // "led off"
    function automatic logic [7:0] cmd_off_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = "l";
            3'd1:    ch = "e";
            3'd2:    ch = "d";
            3'd3:    ch = " ";
            3'd4:    ch = "o";
            3'd5:    ch = "f";
            3'd6:    ch = "f";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // "status"
    function automatic logic [7:0] cmd_status_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = "s";
            3'd1:    ch = "t";
            3'd2:    ch = "a";
            3'd3:    ch = "t";
            3'd4:    ch = "u";
            3'd5:    ch = "s";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // "led is on right now" CR LF
    function automatic logic [7:0] reply_on_char(input logic [4:0] idx);
        logic [7:0] ch;
        case (idx)
            5'd0:    ch = "l";
            5'd1:    ch = "e";
            5'd2:    ch = "d";
            5'd3:    ch = " ";
            5'd4:    ch = "i";
            5'd5:    ch = "s";
            5'd6:    ch = " ";
            5'd7:    ch = "o";
            5'd8:    ch = "n";
            5'd9:    ch = " ";
            5'd10:   ch = "r";
            5'd11:   ch = "i";
            5'd12:   ch = "g";
            5'd13:   ch = "h";
            5'd14:   ch = "t";
            5'd15:   ch = " ";
            5'd16:   ch = "n";
            5'd17:   ch = "o";
            5'd18:   ch = "w";
            5'd19:   ch = CHAR_CR;
            5'd20:   ch = CHAR_LF;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // "led is off right now" CR LF
    function automatic logic [7:0] reply_off_char(input logic [4:0] idx);
        logic [7:0] ch;
        case (idx)
            5'd0:    ch = "l";
            5'd1:    ch = "e";
            5'd2:    ch = "d";
            5'd3:    ch = " ";
            5'd4:    ch = "i";
            5'd5:    ch = "s";
            5'd6:    ch = " ";
            5'd7:    ch = "o";
            5'd8:    ch = "f";
            5'd9:    ch = "f";
            5'd10:   ch = " ";
            5'd11:   ch = "r";
            5'd12:   ch = "i";
            5'd13:   ch = "g";
            5'd14:   ch = "h";
            5'd15:   ch = "t";
            5'd16:   ch = " ";
            5'd17:   ch = "n";
            5'd18:   ch = "o";
            5'd19:   ch = "w";
            5'd20:   ch = CHAR_CR;
            5'd21:   ch = CHAR_LF;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

// File: rtl/tcld_if.sv
// tcld_if: valid/ready channel interfaces for received and transmitted bytes.
// No dependencies.
`default_nettype none

interface tcld_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface tcld_tx_if;
    logic       valid;
    logic       ready;
    logic [7:0] tx_byte;
    logic       led_on;
    logic       last;

    modport source (output valid, output tx_byte, output led_on, output last, input ready);
    modport sink   (input valid, input tx_byte, input led_on, input last, output ready);
endinterface

`default_nettype wire

// File: rtl/tcld_line.sv
// tcld_line: line tracking and command match for each received byte.
// Depends on tcld_pkg and tcld_if.
`default_nettype none

module tcld_line
    import tcld_pkg::*;
#(
    parameter int LINE_CHARS = LINE_CHARS_DEF
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    tcld_rx_if.sink    rx,
    output tcld_job_t  job,
    output logic       job_valid,
    input  wire logic  job_ready
);

    localparam int LEN_W = $clog2(LINE_CHARS + 1);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(LINE_CHARS);

    // The line is kept as its length plus one prefix-match flag per command;
    // a flag stays set while every stored character matches that command.
    logic [LEN_W-1:0] len_reg, len_next;
    logic             m_on_reg, m_on_next;
    logic             m_off_reg, m_off_next;
    logic             m_st_reg, m_st_next;
    logic             led_reg, led_next;

    logic [7:0] ch;
    logic [2:0] pos;
    logic       is_end;
    logic       accept;
    logic       hit_on, hit_off, hit_st;

    assign ch        = rx.rx_byte;
    assign pos       = len_reg[2:0];
    assign is_end    = (ch == CHAR_CR) || (ch == CHAR_LF);
    assign accept    = rx.valid && job_ready;
    assign rx.ready  = job_ready;
    assign job_valid = rx.valid;

    assign hit_on  = m_on_reg  && (len_reg == LEN_W'(CMD_ON_LEN));
    assign hit_off = m_off_reg && (len_reg == LEN_W'(CMD_OFF_LEN));
    assign hit_st  = m_st_reg  && (len_reg == LEN_W'(CMD_STATUS_LEN));

    always_comb
    begin
        len_next   = len_reg;
        m_on_next  = m_on_reg;
        m_off_next = m_off_reg;
        m_st_next  = m_st_reg;
        led_next   = led_reg;
        job.echo   = ch;
        job.kind   = REPLY_NONE;
        if (is_end)
        begin
            len_next   = '0;
            m_on_next  = 1'b1;
            m_off_next = 1'b1;
            m_st_next  = 1'b1;
            if (hit_on)
            begin
                led_next = 1'b1;
            end
            else if (hit_off)
            begin
                led_next = 1'b0;
            end
            else if (hit_st)
            begin
                job.kind = led_reg ? REPLY_ON : REPLY_OFF;
            end
        end
        else if (len_reg < LEN_MAX)
        begin
            // room left: count the character and advance the match flags;
            // on a full line it is dropped and the flags stay as they are
            len_next   = len_reg + LEN_W'(1);
            m_on_next  = m_on_reg && (len_reg < LEN_W'(CMD_ON_LEN))
                         && (ch == cmd_on_char(pos));
            m_off_next = m_off_reg && (len_reg < LEN_W'(CMD_OFF_LEN))
                         && (ch == cmd_off_char(pos));
            m_st_next  = m_st_reg && (len_reg < LEN_W'(CMD_STATUS_LEN))
                         && (ch == cmd_status_char(pos));
        end
        job.led = led_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg   <= '0;
            m_on_reg  <= 1'b1;
            m_off_reg <= 1'b1;
            m_st_reg  <= 1'b1;
            led_reg   <= 1'b0;
        end
        else if (accept)
        begin
            len_reg   <= len_next;
            m_on_reg  <= m_on_next;
            m_off_reg <= m_off_next;
            m_st_reg  <= m_st_next;
            led_reg   <= led_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/tcld_emit.sv
// tcld_emit: holds one decoded transaction and plays out its echo and reply
// bytes through a registered output stage. Depends on tcld_pkg and tcld_if.
`default_nettype none

module tcld_emit
    import tcld_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire tcld_job_t  job,
    input  wire logic       job_valid,
    output logic            job_ready,
    tcld_tx_if.source       tx
);

    tcld_job_t  job_reg;
    logic       job_valid_reg;
    logic [4:0] idx_reg;
    logic [4:0] ridx;

    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       out_led_reg;
    logic       out_last_reg;

    logic [7:0] cur_byte;
    logic       cur_last;
    logic       out_load;

    assign ridx = idx_reg - 5'd1;

    always_comb
    begin
        if (idx_reg == 5'd0)
        begin
            cur_byte = job_reg.echo;
        end
        else if (job_reg.kind == REPLY_ON)
        begin
            cur_byte = reply_on_char(ridx);
        end
        else
        begin
            cur_byte = reply_off_char(ridx);
        end
        case (job_reg.kind)
            REPLY_ON:  cur_last = (idx_reg == 5'(REPLY_ON_LEN));
            REPLY_OFF: cur_last = (idx_reg == 5'(REPLY_OFF_LEN));
            default:   cur_last = (idx_reg == 5'd0);
        endcase
    end

    assign out_load  = job_valid_reg && (!out_valid_reg || tx.ready);
    assign job_ready = !job_valid_reg || (out_load && cur_last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (job_ready)
            begin
                job_valid_reg <= job_valid;
                idx_reg       <= '0;
            end
            else if (out_load)
            begin
                idx_reg <= idx_reg + 5'd1;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (tx.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_ready)
        begin
            job_reg <= job;
        end
        if (out_load)
        begin
            out_byte_reg <= cur_byte;
            out_led_reg  <= job_reg.led;
            out_last_reg <= cur_last;
        end
    end

    assign tx.valid   = out_valid_reg;
    assign tx.tx_byte = out_byte_reg;
    assign tx.led_on  = out_led_reg;
    assign tx.last    = out_last_reg;

endmodule

`default_nettype wire

// File: rtl/text_command_line_decoder_unit.sv
// Text command line decoder, top level.
// The echo goes out first, through the job register and then the output register.
// A character or a line end without a reply frees the input when its echo is loaded
//   into the output stage; a status line waits for the emitter's byte counter.
// Reset (rst_n, async, active low): empty line, LED off, no pending output.
`default_nettype none

module text_command_line_decoder_unit
    import tcld_pkg::*;
#(
    parameter int LINE_CHARS = LINE_CHARS_DEF
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    tcld_rx_if.sink    rx,
    tcld_tx_if.source  tx
);

    // Decoded transaction between line tracker and emitter. The emitter's
    // job register is the input register; the next byte is taken in the
    // same cycle the previous job hands its final byte to the output stage,
    // so back-to-back characters stream at one per cycle while the output is not stalled.
    tcld_job_t job;
    logic      job_valid;
    logic      job_ready;

    // Line length, per-command match flags and LED flag update as each byte
    // is accepted; command matching is incremental, so a line end resolves
    // with a length compare and one flag per command.
    tcld_line #(
        .LINE_CHARS (LINE_CHARS)
    ) u_line (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx        (rx),
        .job       (job),
        .job_valid (job_valid),
        .job_ready (job_ready)
    );

    // Echo first, then the status reply if any; last marks the run end.
    tcld_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (job),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .tx        (tx)
    );

endmodule

`default_nettype wire

// File: tb/text_command_line_decoder_unit_tb.sv
// Self-checking testbench for text_command_line_decoder_unit: drives received bytes and
// checks every echo and status reply against a behavioral line decoder kept in step here.
// Depends on rtl/tcld_pkg.sv, rtl/tcld_if.sv and the decoder RTL.
module text_command_line_decoder_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tcld_pkg::*;

    localparam int STUCK_LIMIT = 500;   // cycles with no transaction on either side
    localparam int TAIL_CYCLES = 8;     // settle time after the last expected byte
    localparam int ITEM_TARGET = 410;

    // One transmitted byte as the checker expects it
    typedef struct packed {
        logic [7:0] tx_byte;
        logic       led_on;
        logic       last;
    } tx_beat_t;

    // Ways a command line gets broken in the random stream
    typedef enum int {
        FAULT_SWAP,
        FAULT_DROP,
        FAULT_EXTRA
    } line_fault_t;

    logic clk;
    logic rst_n;

    tcld_rx_if rx_ch ();
    tcld_tx_if tx_ch ();

    text_command_line_decoder_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_ch),
        .tx    (tx_ch)
    );

    always #6 clk = ~clk;

    // ---------------------------------------------------------------------
    // Line decoder state, mirrored from the block's behavior
    // ---------------------------------------------------------------------
    logic [7:0]  line_chars [LINE_CHARS_DEF];
    int unsigned line_len = 0;
    bit          led_lit  = 1'b0;

    tx_beat_t    pending_tx [$];   // bytes still owed by the block, oldest first
    int unsigned mismatches = 0;
    int unsigned rx_sent    = 0;
    int unsigned stuck_cycles = 0;
    bit          bursty     = 1'b1; // random idling on both channels
    int unsigned tx_stall   = 0;

    // Whole-line compare; a line with any extra or foreign byte never matches
    function automatic bit line_equals(string word);
        if (line_len != word.len())
            return 1'b0;
        foreach (word[i])
            if (line_chars[i] != word[i])
                return 1'b0;
        return 1'b1;
    endfunction

    // Works out every byte one received character causes and queues them
    function automatic void decode_rx_byte(logic [7:0] c);
        logic [7:0] sent [$];
        string      reply;
        reply = "";
        sent.push_back(c);  // the echo always goes first
        if (c == CHAR_CR || c == CHAR_LF)
        begin
            if (line_equals("led on"))
                led_lit = 1'b1;
            else if (line_equals("led off"))
                led_lit = 1'b0;
            else if (line_equals("status"))
                reply = led_lit ? "led is on right now" : "led is off right now";
            foreach (reply[i])
                sent.push_back(reply[i]);
            if (reply.len() != 0)
            begin
                sent.push_back(CHAR_CR);
                sent.push_back(CHAR_LF);
            end
            line_len = 0;
        end
        else if (line_len < LINE_CHARS_DEF)
        begin
            line_chars[line_len] = c;
            line_len++;
        end
        // when the line is full the byte is only echoed
        foreach (sent[k])
            pending_tx.push_back('{tx_byte: sent[k], led_on: led_lit,
                                   last: (k == sent.size() - 1)});
    endfunction

    task automatic note_mismatch(string detail);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] mismatch: %s", $time, detail);
    endtask

    // ---------------------------------------------------------------------
    // Output side: random backpressure in bursts, and the checker
    // ---------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            tx_stall <= 0;
            tx_ch.ready <= 1'b0;
        end
        else if (tx_stall != 0)
        begin
            tx_stall <= tx_stall - 1;
            tx_ch.ready <= 1'b0;
        end
        else if (bursty && $urandom_range(0, 9) == 0)
        begin
            tx_stall <= $urandom_range(0, 5);
            tx_ch.ready <= 1'b0;
        end
        else
        begin
            tx_ch.ready <= 1'b1;
        end
    end

    // Outputs are sampled at the edge, before the block's own updates land
    always @(posedge clk)
    begin : check_tx
        tx_beat_t want;
        if (rst_n && tx_ch.valid && tx_ch.ready)
        begin
            if (pending_tx.size() == 0)
            begin
                note_mismatch($sformatf("unexpected transaction, tx_byte %02h led_on %0b last %0b",
                                        tx_ch.tx_byte, tx_ch.led_on, tx_ch.last));
            end
            else
            begin
                want = pending_tx.pop_front();
                if (tx_ch.tx_byte !== want.tx_byte)
                    note_mismatch($sformatf("tx_byte expected %02h, got %02h",
                                            want.tx_byte, tx_ch.tx_byte));
                if (tx_ch.led_on !== want.led_on)
                    note_mismatch($sformatf("led_on expected %0b, got %0b",
                                            want.led_on, tx_ch.led_on));
                if (tx_ch.last !== want.last)
                    note_mismatch($sformatf("last expected %0b, got %0b",
                                            want.last, tx_ch.last));
            end
        end
    end

    // Watchdog: a long stretch with no transaction anywhere means a hang
    always @(posedge clk)
    begin
        if (!rst_n || (rx_ch.valid && rx_ch.ready) || (tx_ch.valid && tx_ch.ready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    initial
    begin
        wait (stuck_cycles >= STUCK_LIMIT);
        $display("simulation failed");
        $finish;
    end

    // ---------------------------------------------------------------------
    // Input side
    // ---------------------------------------------------------------------
    // One character per transaction; an optional idle burst goes in front.
    // Valid stays high between back-to-back characters.
    task automatic send_char(input logic [7:0] c);
        int unsigned gap;
        if (bursty && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 6);
            rx_ch.valid   <= 1'b0;
            rx_ch.rx_byte <= 8'($urandom);
            repeat (gap) @(posedge clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= c;
        do
            @(posedge clk);
        while (!rx_ch.ready);
        decode_rx_byte(c);
        rx_sent++;
    endtask

    task automatic send_text(string s);
        foreach (s[i])
            send_char(s[i]);
    endtask

    task automatic send_line(string s, logic [7:0] ending);
        send_text(s);
        send_char(ending);
    endtask

    // CR, LF or CR LF, picked at random
    task automatic send_ending();
        case ($urandom_range(0, 2))
            0:       send_char(CHAR_CR);
            1:       send_char(CHAR_LF);
            default:
            begin
                send_char(CHAR_CR);
                send_char(CHAR_LF);
            end
        endcase
    endtask

    // Sender holds off until every owed byte has come out
    task automatic hold_until_drained();
        rx_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_tx.size() != 0);
    endtask

    // Mostly clean commands, then broken commands, short noise and long lines
    task automatic send_random_line();
        logic [7:0]  chars [$];
        string       word;
        int unsigned pick;
        int unsigned n;
        line_fault_t fault;
        case ($urandom_range(0, 2))
            0:       word = "led on";
            1:       word = "led off";
            default: word = "status";
        endcase
        pick = $urandom_range(0, 99);
        if (pick < 55)
        begin
            foreach (word[i])
                chars.push_back(word[i]);
        end
        else if (pick < 72)
        begin
            foreach (word[i])
                chars.push_back(word[i]);
            fault = line_fault_t'($urandom_range(0, 2));
            n = $urandom_range(0, chars.size() - 1);
            case (fault)
                FAULT_SWAP: chars[n] = 8'($urandom);
                FAULT_DROP: chars.delete(n);
                default:    chars.insert(n, 8'($urandom));
            endcase
        end
        else if (pick < 88)
        begin
            // raw bytes; a stray CR or LF just ends the line early
            n = $urandom_range(0, 12);
            repeat (n) chars.push_back(8'($urandom));
        end
        else
        begin
            // long line that may overrun the store, sometimes starting with a valid command
            if (pick[0])
                foreach (word[i])
                    chars.push_back(word[i]);
            n = $urandom_range(LINE_CHARS_DEF - 5, LINE_CHARS_DEF + 9);
            while (chars.size() < n)
                chars.push_back(8'($urandom_range(32, 126)));
        end
        foreach (chars[i])
            send_char(chars[i]);
        send_ending();
    endtask

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------
    task automatic test_commands();
        send_line("status", CHAR_CR);       // off reply straight out of reset
        send_line("led on", CHAR_CR);
        send_line("status", CHAR_LF);       // on reply
        send_line("led off", CHAR_LF);
        send_line("status", CHAR_CR);       // CR LF: the LF ends an empty line
        send_char(CHAR_LF);
    endtask

    task automatic test_odd_lines();
        send_char(CHAR_CR);                 // empty line
        send_char(8'h00);                   // zero byte spoils the command
        send_line("led on", CHAR_CR);
        send_char(8'hFF);
        send_line("status", CHAR_LF);
        send_line("led of", CHAR_CR);       // unknown line
        send_line("status", CHAR_CR);       // LED must still be off
    endtask

    task automatic test_line_full();
        // command prefix, then past the store size: extra bytes are dropped
        send_text("status");
        repeat (LINE_CHARS_DEF - 6 + 4) send_char(8'($urandom_range(32, 126)));
        send_char(CHAR_CR);
        // exactly full line
        repeat (LINE_CHARS_DEF) send_char("z");
        send_char(CHAR_LF);
        // store must be empty again
        send_line("status", CHAR_CR);
    endtask

    task automatic test_random_lines();
        while (rx_sent < 200)
            send_random_line();
        hold_until_drained();   // the block must finish with no input pending
        while (rx_sent < 330)
            send_random_line();
    endtask

    task automatic test_steady_stream();
        bursty = 1'b0;
        while (rx_sent < ITEM_TARGET)
            send_random_line();
    endtask

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        rx_ch.valid   = 1'b0;
        rx_ch.rx_byte = 8'h00;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        test_commands();
        test_odd_lines();
        test_line_full();
        test_random_lines();
        test_steady_stream();

        hold_until_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_tx.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
